// ===== hw/rtl/asc_pkg.sv =====
// shared types, constants and helpers for the adc spike canceller
package asc_pkg;

    localparam int PAD_COUNT_DEF      = 16;
    localparam int INPUTS_PER_PAD_DEF = 8;

    localparam int SAMPLE_W = 16;
    localparam int OVL_W    = 2;
    localparam int LEVEL_W  = 3;
    localparam int NOISE_W  = 15;
    localparam int PAD_W    = 4;
    localparam int SUB_W    = 3;

    localparam int CLASS_DEPTH  = 5;
    localparam int SAMPLE_DEPTH = 4;

    localparam logic [NOISE_W-1:0]  NOISE_RESET = 15'd8;
    localparam logic signed [SAMPLE_W-1:0] SPIKE_LIMIT = 16'sd150;

    typedef enum logic [1:0] {
        CL_NOISE = 2'd0,
        CL_HIGH  = 2'd1,
        CL_LOW   = 2'd2,
        CL_OTHER = 2'd3
    } cls_t;

    // one channel's history, index 0 is the newest
    typedef struct packed {
        cls_t [CLASS_DEPTH-1:0]                  cls;
        logic [SAMPLE_DEPTH-1:0][SAMPLE_W-1:0]   smp;
        logic [SAMPLE_DEPTH-1:0][OVL_W-1:0]      ovl;
    } entry_t;

    localparam entry_t ENTRY_RESET = entry_t'({{CLASS_DEPTH{CL_OTHER}},
                                               {(SAMPLE_DEPTH*SAMPLE_W){1'b0}},
                                               {(SAMPLE_DEPTH*OVL_W){1'b0}}});

    // a class that closes a run of the given spike class on either side
    function automatic logic frames(cls_t c, cls_t run);
        return (c == CL_NOISE) || ((c != run) && ((c == CL_HIGH) || (c == CL_LOW)));
    endfunction

endpackage

// ===== hw/rtl/asc_sample_if.sv =====
// request channel carrying one sample and its channel address
interface asc_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic [asc_pkg::PAD_W-1:0]             pad_number;
    logic [asc_pkg::SUB_W-1:0]             pad_input_number;
    logic signed [asc_pkg::SAMPLE_W-1:0]   sample_in;
    logic [asc_pkg::OVL_W-1:0]             overload_in;
    logic [asc_pkg::LEVEL_W-1:0]           cancel_level;

    modport source (
        output valid, pad_number, pad_input_number, sample_in, overload_in, cancel_level,
        input  ready
    );
    modport sink (
        input  valid, pad_number, pad_input_number, sample_in, overload_in, cancel_level,
        output ready
    );
endinterface

// ===== hw/rtl/asc_result_if.sv =====
// result channel carrying the delayed, possibly cancelled sample
interface asc_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [asc_pkg::SAMPLE_W-1:0]   sample_out;
    logic [asc_pkg::OVL_W-1:0]             overload_out;

    modport source (
        output valid, sample_out, overload_out,
        input  ready
    );
    modport sink (
        input  valid, sample_out, overload_out,
        output ready
    );
endinterface

// ===== hw/rtl/adc_spike_canceller_unit.sv =====
// adc spike canceller: per channel history memory with read-modify-write pipeline
//
//  channel    dir  handshake          payload
//  samples    in   valid / ready      pad_number, pad_input_number, sample_in,
//                                     overload_in, cancel_level
//  results    out  valid / ready      sample_out, overload_out
//  cfg        in   cfg_wr_en          cfg_wr_data (noise_amplitude)
//
// one request per cycle unless stalled; results pass the request stage and result register
// the history memory is read at acceptance and written back as the request leaves its stage,
// a write-back register forwards the latest entry to a following same-channel request
// reset clears per-entry valid bits at once, so no clearing pass is needed
// a stalled result register holds the stage behind it, requests wait only when both are full
module adc_spike_canceller_unit #(
    parameter int PAD_COUNT      = asc_pkg::PAD_COUNT_DEF,
    parameter int INPUTS_PER_PAD = asc_pkg::INPUTS_PER_PAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [asc_pkg::NOISE_W-1:0]   cfg_wr_data,
    asc_sample_if.sink                    samples,
    asc_result_if.source                  results
);
    import asc_pkg::*;

    localparam int CH_COUNT = PAD_COUNT * INPUTS_PER_PAD;
    localparam int ADDR_W   = (CH_COUNT > 1) ? $clog2(CH_COUNT) : 1;

    logic [NOISE_W-1:0] noise_amp_reg;

    // history memory and its valid bits
    entry_t              mem [CH_COUNT];
    logic [CH_COUNT-1:0] vld_reg;

    // request stage
    logic                  s1_valid_reg;
    logic                  s1_inr_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic signed [SAMPLE_W-1:0] s1_smp_reg;
    logic [OVL_W-1:0]      s1_ovl_reg;
    logic [LEVEL_W-1:0]    s1_lvl_reg;
    logic                  s1_ent_vld_reg;
    entry_t                rd_data_reg;

    // latest write-back for forwarding
    logic                  wb_valid_reg;
    logic [ADDR_W-1:0]     wb_addr_reg;
    entry_t                wb_data_reg;

    // result register
    logic                  out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_smp_reg;
    logic [OVL_W-1:0]      out_ovl_reg;

    logic                  in_acc;
    logic                  s1_adv;
    logic                  in_range;
    logic [ADDR_W-1:0]     in_addr;
    logic [31:0]           addr_full;
    logic                  mem_we;

    entry_t                cur;
    entry_t                entry_next;
    logic [SAMPLE_W:0]     mag;
    cls_t                  cl;
    cls_t                  seq [6];
    cls_t                  run;
    logic [LEVEL_W-1:0]    maxlen;
    logic [1:0]            slot;
    logic                  hit;
    logic                  any_hit;
    logic [SAMPLE_DEPTH-2:0] zero_mask;
    logic [SAMPLE_DEPTH-1:0][SAMPLE_W-1:0] zs;
    logic signed [SAMPLE_W-1:0] res_smp_next;
    logic [OVL_W-1:0]      res_ovl_next;

    assign s1_adv         = s1_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready  = !s1_valid_reg || s1_adv;
    assign in_acc         = samples.valid && samples.ready;

    assign in_range  = (32'(samples.pad_number) < PAD_COUNT)
                    && (32'(samples.pad_input_number) < INPUTS_PER_PAD);
    assign addr_full = 32'(samples.pad_number) * INPUTS_PER_PAD
                     + 32'(samples.pad_input_number);
    assign in_addr   = addr_full[ADDR_W-1:0];

    assign mem_we    = s1_adv && s1_inr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_amp_reg <= NOISE_RESET;
        end
        else if (cfg_wr_en)
        begin
            noise_amp_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[s1_addr_reg] <= entry_next;
        end
        if (in_acc && in_range)
        begin
            rd_data_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s1_ent_vld_reg <= 1'b0;
            wb_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[s1_addr_reg] <= 1'b1;
                wb_valid_reg         <= 1'b1;
            end
            if (in_acc)
            begin
                s1_valid_reg   <= 1'b1;
                s1_ent_vld_reg <= vld_reg[in_addr];
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_inr_reg  <= in_range;
            s1_addr_reg <= in_addr;
            s1_smp_reg  <= samples.sample_in;
            s1_ovl_reg  <= samples.overload_in;
            s1_lvl_reg  <= samples.cancel_level;
        end
        if (mem_we)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= entry_next;
        end
        if (s1_adv)
        begin
            out_smp_reg <= res_smp_next;
            out_ovl_reg <= res_ovl_next;
        end
    end

    // classify, detect runs, build the shifted entry and pick the result
    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == s1_addr_reg))
        begin
            cur = wb_data_reg;
        end
        else if (s1_ent_vld_reg)
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = ENTRY_RESET;
        end

        mag = s1_smp_reg[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {s1_smp_reg[SAMPLE_W-1], s1_smp_reg})
                                     : {1'b0, s1_smp_reg};
        if (mag < {2'b00, noise_amp_reg})
        begin
            cl = CL_NOISE;
        end
        else if ((s1_smp_reg > 16'sd0) && (s1_smp_reg < SPIKE_LIMIT))
        begin
            cl = CL_HIGH;
        end
        else if ((s1_smp_reg < 16'sd0) && (s1_smp_reg > -SPIKE_LIMIT))
        begin
            cl = CL_LOW;
        end
        else
        begin
            cl = CL_OTHER;
        end

        // oldest first, new class last
        seq[0] = cur.cls[4];
        seq[1] = cur.cls[3];
        seq[2] = cur.cls[2];
        seq[3] = cur.cls[1];
        seq[4] = cur.cls[0];
        seq[5] = cl;

        if (s1_lvl_reg == 3'd0)
        begin
            maxlen = 3'd1;
        end
        else if (s1_lvl_reg > 3'd4)
        begin
            maxlen = 3'd4;
        end
        else
        begin
            maxlen = s1_lvl_reg;
        end

        any_hit   = 1'b0;
        zero_mask = '0;
        hit       = 1'b0;
        run       = CL_HIGH;
        for (int n = 1; n <= 4; n++)
        begin
            for (int kind = 0; kind < 2; kind++)
            begin
                run = (kind == 1) ? CL_LOW : CL_HIGH;
                hit = (3'(n) <= maxlen) && frames(seq[0], run) && frames(seq[n+1], run);
                for (int k = 1; k <= n; k++)
                begin
                    if (seq[k] != run)
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    any_hit = 1'b1;
                    // zero the inner samples of the run, index 2 down to 0
                    for (int k = 1; k < n; k++)
                    begin
                        zero_mask[3-k] = 1'b1;
                    end
                end
            end
        end

        for (int i = 0; i < SAMPLE_DEPTH; i++)
        begin
            zs[i] = cur.smp[i];
        end
        for (int i = 0; i < SAMPLE_DEPTH - 1; i++)
        begin
            if (zero_mask[i])
            begin
                zs[i] = '0;
            end
        end

        if (s1_lvl_reg >= 3'd3)
        begin
            slot = 2'd0;
        end
        else if (s1_lvl_reg == 3'd2)
        begin
            slot = 2'd1;
        end
        else
        begin
            slot = 2'd2;
        end

        entry_next.cls[4] = cur.cls[3];
        entry_next.cls[3] = cur.cls[2];
        entry_next.cls[2] = cur.cls[1];
        entry_next.cls[1] = cur.cls[0];
        entry_next.cls[0] = cur.cls[0];
        entry_next.smp[3] = zs[2];
        entry_next.smp[2] = zs[1];
        entry_next.smp[1] = zs[0];
        entry_next.smp[0] = zs[0];
        entry_next.ovl[3] = cur.ovl[2];
        entry_next.ovl[2] = cur.ovl[1];
        entry_next.ovl[1] = cur.ovl[0];
        entry_next.ovl[0] = cur.ovl[0];
        entry_next.cls[slot] = cl;
        entry_next.smp[slot] = s1_smp_reg;
        entry_next.ovl[slot] = s1_ovl_reg;

        if (!s1_inr_reg)
        begin
            res_smp_next = '0;
            res_ovl_next = '0;
        end
        else
        begin
            res_smp_next = any_hit ? '0 : cur.smp[3];
            res_ovl_next = cur.ovl[3];
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.sample_out   = out_smp_reg;
    assign results.overload_out = out_ovl_reg;

endmodule

// ===== hw/rtl/asc_checker.sv =====
// port-level checks for the adc spike canceller, bound to the top level
module asc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    logic [1:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // requests accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without a pending request");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more requests in flight than stages");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request stalled with a free result register");

endmodule

bind adc_spike_canceller_unit asc_checker u_asc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready)
);

// ===== tb/adc_spike_canceller_unit_tb.sv =====
// testbench for the adc spike canceller: queued requests, self-predicting result checks
`timescale 1ns / 1ps

module adc_spike_canceller_unit_tb;
    import asc_pkg::*;

    localparam int PADS         = PAD_COUNT_DEF;
    localparam int SUBS         = INPUTS_PER_PAD_DEF;
    localparam int CHANNELS     = PADS * SUBS;
    localparam int SPIKE_BOUND  = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LINES = 40;

    typedef struct {
        logic [PAD_W-1:0]           pad;
        logic [SUB_W-1:0]           sub;
        logic signed [SAMPLE_W-1:0] smp;
        logic [OVL_W-1:0]           ovl;
        logic [LEVEL_W-1:0]         lvl;
    } sample_req_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic [OVL_W-1:0]           ovl;
    } delayed_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [NOISE_W-1:0]   cfg_wr_data;

    asc_sample_if samples ();
    asc_result_if results ();

    adc_spike_canceller_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (samples),
        .results     (results)
    );

    // predictor state, one history per channel, index 0 newest
    logic [NOISE_W-1:0]         noise_amp;
    cls_t                       hist_cls [CHANNELS][CLASS_DEPTH];
    logic signed [SAMPLE_W-1:0] hist_smp [CHANNELS][SAMPLE_DEPTH];
    logic [OVL_W-1:0]           hist_ovl [CHANNELS][SAMPLE_DEPTH];

    sample_req_t sample_req_q [$];
    delayed_t    delayed_q [$];
    sample_req_t cur_req;
    delayed_t    want;
    delayed_t    due;

    int queued_total  = 0;
    int issued_count  = 0;
    int results_seen  = 0;
    int errors        = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int rcv_stall_pct = 0;
    int hold_left     = 0;
    logic hold_go     = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input int got, input int exp_val);
        if (errors < REPORT_LINES)
            $display("result %0d: %s = %0d, predicted %0d", results_seen, what, got, exp_val);
        errors++;
    endtask

    function automatic logic closes_run(cls_t c, cls_t run);
        return (c == CL_NOISE) || ((c != run) && ((c == CL_HIGH) || (c == CL_LOW)));
    endfunction

    function automatic void predict_delayed_sample(input sample_req_t r, output delayed_t d);
        int ch, mag, maxlen, slot, n, kind, k;
        logic signed [SAMPLE_W-1:0] x;
        cls_t cl;
        cls_t run;
        cls_t seq [6];
        logic hit;
        d.smp = '0;
        d.ovl = '0;
        // channel outside the array: no state change, zero result
        if (int'(r.pad) >= PADS || int'(r.sub) >= SUBS)
            return;
        ch = int'(r.pad) * SUBS + int'(r.sub);
        x = r.smp;
        mag = (x < 0) ? -int'(x) : int'(x);
        if (mag < int'(noise_amp))
            cl = CL_NOISE;
        else if (x > 0 && x < SPIKE_BOUND)
            cl = CL_HIGH;
        else if (x < 0 && x > -SPIKE_BOUND)
            cl = CL_LOW;
        else
            cl = CL_OTHER;

        d.smp = hist_smp[ch][SAMPLE_DEPTH-1];
        d.ovl = hist_ovl[ch][SAMPLE_DEPTH-1];

        // oldest class first, new class last
        for (k = 0; k < CLASS_DEPTH; k++)
            seq[k] = hist_cls[ch][CLASS_DEPTH-1-k];
        seq[5] = cl;

        maxlen = (r.lvl < 1) ? 1 : ((r.lvl > 4) ? 4 : int'(r.lvl));
        for (n = 1; n <= maxlen; n++)
        begin
            for (kind = 0; kind < 2; kind++)
            begin
                run = kind ? CL_LOW : CL_HIGH;
                hit = closes_run(seq[0], run) && closes_run(seq[n+1], run);
                for (k = 1; k <= n; k++)
                    if (seq[k] != run)
                        hit = 1'b0;
                if (hit)
                begin
                    d.smp = '0;
                    for (k = 1; k < n; k++)
                        hist_smp[ch][3-k] = '0;
                end
            end
        end

        for (k = CLASS_DEPTH - 1; k > 0; k--)
            hist_cls[ch][k] = hist_cls[ch][k-1];
        for (k = SAMPLE_DEPTH - 1; k > 0; k--)
        begin
            hist_smp[ch][k] = hist_smp[ch][k-1];
            hist_ovl[ch][k] = hist_ovl[ch][k-1];
        end
        slot = (r.lvl >= 3) ? 0 : ((r.lvl == 2) ? 1 : 2);
        hist_cls[ch][slot] = cl;
        hist_smp[ch][slot] = x;
        hist_ovl[ch][slot] = r.ovl;
    endfunction

    // a sample value aimed at the wanted class under the present threshold, random where none fits
    function automatic logic signed [SAMPLE_W-1:0] value_of_class(cls_t k);
        int lo, m;
        logic signed [SAMPLE_W-1:0] v;
        v = 16'($urandom_range(65535, 0));
        case (k)
            CL_NOISE:
            begin
                if (noise_amp != 0)
                begin
                    m = $urandom_range(int'(noise_amp) - 1, 0);
                    v = $urandom_range(1, 0) ? 16'(-m) : 16'(m);
                end
            end
            CL_HIGH, CL_LOW:
            begin
                lo = (noise_amp > 1) ? int'(noise_amp) : 1;
                if (lo < SPIKE_BOUND)
                begin
                    m = $urandom_range(SPIKE_BOUND - 1, lo);
                    v = (k == CL_LOW) ? 16'(-m) : 16'(m);
                end
            end
            default:
            begin
                m = $urandom_range(32767, SPIKE_BOUND);
                v = $urandom_range(1, 0) ? 16'(-m) : 16'(m);
                if ($urandom_range(15, 0) == 0)
                    v = 16'sh8000;
            end
        endcase
        return v;
    endfunction

    task automatic queue_item(input logic [PAD_W-1:0] pad, input logic [SUB_W-1:0] sub,
                              input logic signed [SAMPLE_W-1:0] smp,
                              input logic [OVL_W-1:0] ovl, input logic [LEVEL_W-1:0] lvl);
        sample_req_t r;
        r.pad = pad;
        r.sub = sub;
        r.smp = smp;
        r.ovl = ovl;
        r.lvl = lvl;
        sample_req_q.push_back(r);
        queued_total++;
    endtask

    task automatic queue_random_item();
        queue_item(4'($urandom), 3'($urandom), 16'($urandom), 2'($urandom), 3'($urandom));
    endtask

    task automatic queue_class_sample(input logic [PAD_W-1:0] pad, input logic [SUB_W-1:0] sub,
                                      input cls_t k, input logic [LEVEL_W-1:0] lvl);
        // stray requests on random channels in between
        if ($urandom_range(99, 0) < 15)
            queue_random_item();
        if ($urandom_range(9, 0) == 0)
            lvl = 3'($urandom_range(7, 0));
        queue_item(pad, sub, value_of_class(k), 2'($urandom_range(3, 0)), lvl);
    endtask

    task automatic queue_spike_run();
        logic [PAD_W-1:0]   pad;
        logic [SUB_W-1:0]   sub;
        logic [LEVEL_W-1:0] lvl;
        cls_t run, opp, lead, trail;
        int len;
        pad = 4'($urandom_range(15, 0));
        sub = 3'($urandom_range(7, 0));
        // most runs share a few channels so the histories carry over
        if ($urandom_range(3, 0) != 0)
        begin
            pad[3:2] = 2'b00;
            sub[2:1] = 2'b00;
        end
        lvl = 3'($urandom_range(7, 0));
        run = $urandom_range(1, 0) ? CL_HIGH : CL_LOW;
        opp = (run == CL_HIGH) ? CL_LOW : CL_HIGH;
        len = ($urandom_range(9, 0) == 0) ? 5 : $urandom_range(4, 1);
        lead = $urandom_range(1, 0) ? CL_NOISE : opp;
        trail = $urandom_range(1, 0) ? CL_NOISE : opp;
        // broken frames now and then
        if ($urandom_range(7, 0) == 0)
            lead = CL_OTHER;
        if ($urandom_range(7, 0) == 0)
            trail = CL_OTHER;
        queue_class_sample(pad, sub, lead, lvl);
        repeat (len)
            queue_class_sample(pad, sub, run, lvl);
        queue_class_sample(pad, sub, trail, lvl);
        repeat ($urandom_range(3, 0))
            queue_class_sample(pad, sub, cls_t'($urandom_range(3, 0)), lvl);
    endtask

    task automatic queue_random_phase(input int n);
        int start;
        start = queued_total;
        while (queued_total - start < n)
        begin
            if ($urandom_range(4, 0) == 0)
                queue_random_item();
            else
                queue_spike_run();
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (!(sample_req_q.size() == 0 && issued_count == results_seen));
        repeat (4) @(posedge clk);
    endtask

    task automatic write_noise(input logic [NOISE_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        noise_amp = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int rcv_pct);
        @(posedge clk);
        send_idle_pct <= send_pct;
        rcv_stall_pct <= rcv_pct;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            samples.valid <= 1'b0;
        else
        begin
            if (samples.valid && samples.ready)
            begin
                predict_delayed_sample(cur_req, want);
                delayed_q.push_back(want);
            end
            if (!samples.valid || samples.ready)
            begin
                if (sample_req_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    cur_req = sample_req_q.pop_front();
                    issued_count++;
                    samples.pad_number       <= cur_req.pad;
                    samples.pad_input_number <= cur_req.sub;
                    samples.sample_in        <= cur_req.smp;
                    samples.overload_in      <= cur_req.ovl;
                    samples.cancel_level     <= cur_req.lvl;
                    samples.valid            <= 1'b1;
                end
                else
                    samples.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else
        begin
            if (results.valid && results.ready)
            begin
                results_seen++;
                if (delayed_q.size() == 0)
                    flag_mismatch("unexpected sample_out", results.sample_out, 0);
                else
                begin
                    due = delayed_q.pop_front();
                    if (results.sample_out !== due.smp)
                        flag_mismatch("sample_out", results.sample_out, due.smp);
                    if (results.overload_out !== due.ovl)
                        flag_mismatch("overload_out", results.overload_out, due.ovl);
                end
            end
            results.ready <= (hold_go || hold_left != 0) ? 1'b0
                                                          : ($urandom_range(99, 0) >= rcv_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("adc_spike_canceller_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n                    = 1'b0;
        cfg_wr_en                = 1'b0;
        cfg_wr_data              = '0;
        samples.valid            = 1'b0;
        samples.pad_number       = '0;
        samples.pad_input_number = '0;
        samples.sample_in        = '0;
        samples.overload_in      = '0;
        samples.cancel_level     = '0;
        results.ready            = 1'b0;

        noise_amp = NOISE_RESET;
        for (int i = 0; i < CHANNELS; i++)
        begin
            for (int k = 0; k < CLASS_DEPTH; k++)
                hist_cls[i][k] = CL_OTHER;
            for (int k = 0; k < SAMPLE_DEPTH; k++)
            begin
                hist_smp[i][k] = '0;
                hist_ovl[i][k] = '0;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone high spike between noise, level zero
        queue_item(0, 0, 3, 0, 0);
        queue_item(0, 0, 100, 1, 0);
        queue_item(0, 0, -2, 2, 0);
        queue_item(0, 0, 0, 3, 0);
        queue_item(0, 0, 0, 0, 0);
        // four low spikes with a level above four
        queue_item(15, 7, 1, 1, 7);
        queue_item(15, 7, -40, 2, 7);
        queue_item(15, 7, -41, 3, 7);
        queue_item(15, 7, -42, 0, 7);
        queue_item(15, 7, -43, 1, 7);
        queue_item(15, 7, 5, 2, 7);
        queue_item(15, 7, 0, 3, 7);
        // sample extremes and the spike bound
        queue_item(3, 2, -32768, 0, 2);
        queue_item(3, 2, 32767, 1, 2);
        queue_item(3, 2, 149, 2, 2);
        queue_item(3, 2, 150, 3, 2);
        queue_item(3, 2, -149, 0, 3);
        queue_item(3, 2, -150, 1, 3);
        // high spike framed by low spikes
        queue_item(5, 5, -60, 2, 1);
        queue_item(5, 5, 60, 3, 1);
        queue_item(5, 5, -60, 0, 1);
        queue_item(5, 5, 7, 1, 4);
        queue_item(5, 5, -1, 2, 5);

        queue_random_phase(110);
        wait_idle();

        write_noise(15'd0);
        set_idling(86, 0);
        queue_random_phase(110);
        wait_idle();

        write_noise(15'h7fff);
        set_idling(0, 86);
        queue_random_phase(100);
        wait_idle();

        write_noise(15'd150);
        set_idling(38, 38);
        queue_random_phase(110);
        wait_idle();

        // fill the pipeline against a stalled receiver
        write_noise(15'($urandom_range(160, 1)));
        set_idling(0, 0);
        queue_random_phase(60);
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        wait_idle();
        queue_random_phase(50);
        wait_idle();

        write_noise(15'd1);
        set_idling(38, 38);
        queue_random_phase(100);
        wait_idle();

        write_noise(15'd8);
        set_idling(0, 0);
        queue_random_phase(40);
        wait_idle();

        repeat (8) @(posedge clk);
        if (delayed_q.size() != 0)
            flag_mismatch("results still owed", delayed_q.size(), 0);
        if (errors == 0)
            $display("adc_spike_canceller_unit: match");
        else
            $display("adc_spike_canceller_unit: mismatch");
        $finish;
    end

endmodule
